[sv/stsd_pkg.sv]
// Shared types and constants for the sphere triangle subdivider.
// Used by every module of the block; depends on nothing.
`default_nettype none
package stsd_pkg;

  localparam int COORD_W   = 24;
  localparam int RADIUS_W  = 23;
  localparam int IDX_W     = 32;
  localparam int MAX_DEPTH = 3;
  localparam int IN_W      = 224;
  localparam int OUT_W     = 248;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd65536;

  typedef logic [1:0] lvl_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec_t;

  typedef struct packed {
    vec_t c;
    vec_t b;
    vec_t a;
  } tri_t;

  // which edge midpoint is being projected
  typedef enum logic [1:0] {MID_AB, MID_BC, MID_CA} mid_sel_t;

  // child codes, in traversal order
  localparam logic [1:0] CHILD_A   = 2'd0;
  localparam logic [1:0] CHILD_B   = 2'd1;
  localparam logic [1:0] CHILD_MID = 2'd2;
  localparam logic [1:0] CHILD_C   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     mid_start;
    mid_sel_t mid_sel;
    logic     descend;
    logic [1:0] child;
    logic     emit;
    logic     last;
    lvl_t     lvl;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic proj_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[sv/stsd_proj.sv]
// Midpoint projection unit: floor average, sum of squares, bit-serial integer
// square root and restoring division, one shared multiplier. Uses stsd_pkg.
`default_nettype none
module stsd_proj (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  stsd_pkg::vec_t                p,
  input  stsd_pkg::vec_t                q,
  input  logic [stsd_pkg::RADIUS_W-1:0] radius,
  output logic                          done,
  output stsd_pkg::vec_t                res
);
  import stsd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SQRT, S_MUL, S_DINIT, S_DIV} pstate_t;

  pstate_t     state;
  logic [4:0]  cnt;
  logic [1:0]  comp;
  logic [23:0] mag [3];
  logic        neg [3];
  logic [47:0] prod;
  logic [47:0] acc;
  logic [47:0] v;
  logic [25:0] rem;
  logic [23:0] root;
  logic [23:0] r;
  logic [22:0] dv;
  logic [21:0] quo;
  coord_t      rv [3];

  function automatic coord_t mid_of(coord_t a, coord_t b);
    logic signed [24:0] s;
    begin
      s = {a[23], a} + {b[23], b};
      return s[24:1];
    end
  endfunction

  function automatic logic [23:0] mag_of(coord_t a);
    begin
      return a[23] ? (~a + 24'd1) : a;
    end
  endfunction

  coord_t      mx, my, mz;
  logic [23:0] mul_a, mul_b;
  logic [47:0] mul_p;
  logic [27:0] sq_wide, sq_trial, sq_diff;
  logic        sq_ge;
  logic [24:0] dw, dw_diff;
  logic        dge;
  logic [22:0] qfin;

  assign mx = mid_of(p.x, q.x);
  assign my = mid_of(p.y, q.y);
  assign mz = mid_of(p.z, q.z);

  // shared multiplier: squares, then magnitude times radius
  assign mul_a = mag[comp];
  assign mul_b = (state == S_SQ) ? mag[comp] : {1'b0, radius};
  assign mul_p = mul_a * mul_b;

  // one root bit per cycle
  assign sq_wide  = {rem, v[47:46]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = sq_wide >= sq_trial;
  assign sq_diff  = sq_wide - sq_trial;

  // one quotient bit per cycle
  assign dw      = {r, dv[22]};
  assign dge     = dw >= {1'b0, root};
  assign dw_diff = dw - {1'b0, root};
  assign qfin    = {quo, dge};

  assign res.x = rv[0];
  assign res.y = rv[1];
  assign res.z = rv[2];

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      comp  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            mag[0] <= mag_of(mx);
            mag[1] <= mag_of(my);
            mag[2] <= mag_of(mz);
            neg[0] <= mx[23];
            neg[1] <= my[23];
            neg[2] <= mz[23];
            comp   <= '0;
            cnt    <= '0;
            acc    <= '0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt < 5'd3) prod <= mul_p;
          if (cnt != 5'd0) acc <= acc + prod;
          if (comp != 2'd2) comp <= comp + 2'd1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            v     <= acc + prod;
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            comp  <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem  <= sq_ge ? sq_diff[25:0] : sq_wide[25:0];
          root <= {root[22:0], sq_ge};
          v    <= {v[45:0], 2'b00};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd23) begin
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (root == 24'd0) begin
            // zero-length midpoint
            rv[0] <= '0;
            rv[1] <= '0;
            rv[2] <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            prod  <= mul_p;
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          // quotient is below 2^23, so the top bits start below the divisor
          r     <= prod[46:23];
          dv    <= prod[22:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          r   <= dge ? dw_diff[23:0] : dw[23:0];
          quo <= qfin[21:0];
          dv  <= {dv[21:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd22) begin
            rv[comp] <= neg[comp] ? -{1'b0, qfin} : {1'b0, qfin};
            if (comp == 2'd2) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("projection started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("projection done held for two cycles");

endmodule
`default_nettype wire

[sv/stsd_datapath.sv]
// Datapath: radius register, triangle stack per level, midpoint store,
// projection unit, output register and vertex counter. Uses stsd_pkg, stsd_proj.
`default_nettype none
module stsd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [stsd_pkg::RADIUS_W-1:0] cfg_wr_data,
  input  stsd_pkg::tri_t                in_tri,
  input  stsd_pkg::dp_cmd_t             cmd,
  output stsd_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output stsd_pkg::tri_t                out_tri,
  output logic [stsd_pkg::IDX_W-1:0]    out_base,
  output logic                          out_last
);
  import stsd_pkg::*;

  logic [RADIUS_W-1:0] radius;
  logic [IDX_W-1:0]    vcount;
  tri_t                tri_stk [MAX_DEPTH+1];
  vec_t                mid_stk [MAX_DEPTH][3];

  tri_t   cur;
  tri_t   child_tri;
  vec_t   pp, qq, pres, m_ab, m_bc, m_ca;
  logic   pdone;

  assign cur  = tri_stk[cmd.lvl];
  assign m_ab = mid_stk[cmd.lvl][MID_AB];
  assign m_bc = mid_stk[cmd.lvl][MID_BC];
  assign m_ca = mid_stk[cmd.lvl][MID_CA];

  // edge end points for the projection unit
  always_comb begin
    case (cmd.mid_sel)
      MID_AB: begin pp = cur.a; qq = cur.b; end
      MID_BC: begin pp = cur.c; qq = cur.b; end
      MID_CA: begin pp = cur.a; qq = cur.c; end
      default: begin pp = cur.a; qq = cur.b; end
    endcase
  end

  // child triangle from parent corners and its projected midpoints
  always_comb begin
    case (cmd.child)
      CHILD_A:   child_tri = '{c: m_ca, b: m_ab,  a: cur.a};
      CHILD_B:   child_tri = '{c: m_bc, b: cur.b, a: m_ab};
      CHILD_MID: child_tri = '{c: m_ca, b: m_bc,  a: m_ab};
      default:   child_tri = '{c: cur.c, b: m_bc, a: m_ca};
    endcase
  end

  stsd_proj u_proj (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mid_start),
    .p      (pp),
    .q      (qq),
    .radius (radius),
    .done   (pdone),
    .res    (pres)
  );

  assign stat.proj_done = pdone;
  assign stat.out_free  = !out_valid || out_ready;

  // stacks and result register
  always_ff @(posedge clk) begin
    if (cmd.load_in) tri_stk[0] <= in_tri;
    if (cmd.descend) tri_stk[lvl_t'(cmd.lvl + 2'd1)] <= child_tri;
    if (pdone) mid_stk[cmd.lvl][cmd.mid_sel] <= pres;
    if (cmd.emit) begin
      out_tri  <= cur;
      out_base <= vcount;
      out_last <= cmd.last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RESET;
      vcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) radius <= cfg_wr_data;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        vcount    <= vcount + IDX_W'(3);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready)) else $error("result overwritten");

endmodule
`default_nettype wire

[sv/stsd_ctrl.sv]
// Controller: walks the subdivision tree depth first with a per-level child
// counter and sequences midpoint projection and leaf output. Uses stsd_pkg.
`default_nettype none
module stsd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0]         in_levels,
  output logic               in_ready,
  input  stsd_pkg::dp_stat_t stat,
  output stsd_pkg::dp_cmd_t  cmd
);
  import stsd_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE, C_CHECK, C_MID_GO, C_MID_WAIT, C_DESCEND, C_EMIT, C_ASCEND
  } cstate_t;

  cstate_t    state;
  lvl_t       depth;
  lvl_t       lvl;
  mid_sel_t   mid_idx;
  logic [1:0] child [MAX_DEPTH];
  logic       leaf_last;

  // final leaf when every ancestor is on its last child
  always_comb begin
    leaf_last = 1'b1;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (lvl_t'(i) < depth && child[i] != CHILD_C) leaf_last = 1'b0;
    end
  end

  assign in_ready      = (state == C_IDLE);
  assign cmd.load_in   = (state == C_IDLE) && in_valid;
  assign cmd.mid_start = (state == C_MID_GO);
  assign cmd.mid_sel   = mid_idx;
  assign cmd.descend   = (state == C_DESCEND);
  assign cmd.child     = child[lvl];
  assign cmd.emit      = (state == C_EMIT) && stat.out_free;
  assign cmd.last      = leaf_last;
  assign cmd.lvl       = lvl;

  // tree walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      depth   <= '0;
      lvl     <= '0;
      mid_idx <= MID_AB;
      for (int i = 0; i < MAX_DEPTH; i++) child[i] <= CHILD_A;
    end else begin
      case (state)
        C_IDLE: begin
          if (in_valid) begin
            depth <= (in_levels > 3'(MAX_DEPTH)) ? lvl_t'(MAX_DEPTH) : in_levels[1:0];
            lvl   <= '0;
            state <= C_CHECK;
          end
        end
        C_CHECK: begin
          if (lvl == depth) begin
            state <= C_EMIT;
          end else begin
            mid_idx <= MID_AB;
            state   <= C_MID_GO;
          end
        end
        C_MID_GO: state <= C_MID_WAIT;
        C_MID_WAIT: begin
          if (stat.proj_done) begin
            case (mid_idx)
              MID_AB: begin mid_idx <= MID_BC; state <= C_MID_GO; end
              MID_BC: begin mid_idx <= MID_CA; state <= C_MID_GO; end
              default: begin
                child[lvl] <= CHILD_A;
                state      <= C_DESCEND;
              end
            endcase
          end
        end
        C_DESCEND: begin
          lvl   <= lvl + 2'd1;
          state <= C_CHECK;
        end
        C_EMIT: begin
          if (stat.out_free) begin
            if (leaf_last) begin
              state <= C_IDLE;
            end else begin
              lvl   <= lvl - 2'd1;
              state <= C_ASCEND;
            end
          end
        end
        C_ASCEND: begin
          if (child[lvl] == CHILD_C) begin
            lvl <= lvl - 2'd1;
          end else begin
            child[lvl] <= child[lvl] + 2'd1;
            state      <= C_DESCEND;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  a_lvl_bound: assert property (@(posedge clk) disable iff (rst)
    state != C_IDLE |-> lvl <= depth) else $error("level beyond depth");

endmodule
`default_nettype wire

[sv/sphere_triangle_subdivider.sv]
// Sphere triangle subdivider. Each request carries one triangle and a depth
// (saturated to 3); the block emits 4^depth leaf triangles depth first, each
// with a running base vertex index that advances by 3, tlast on the final leaf.
// New edge midpoints are projected onto the sphere of cfg radius by one shared
// unit that steps through start, squaring, bit-serial root steps, per component
// a multiply, a load and the divide steps, then done; a zero-length midpoint
// skips the load and the divide steps. Depth 3 needs 63 midpoints. A new request
// is taken once the last leaf is in the output register. Depends on stsd_pkg,
// stsd_ctrl, stsd_datapath.
`default_nettype none
module sphere_triangle_subdivider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [stsd_pkg::RADIUS_W-1:0] cfg_wr_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz (24 each), levels (3), zero pad
  input  logic [stsd_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_ax, out_ay, out_az, out_bx, out_by, out_bz, out_cx, out_cy, out_cz
  // (24 each), base_index (32)
  output logic [stsd_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast
);
  import stsd_pkg::*;

  tri_t               in_tri;
  tri_t               out_tri;
  logic [IDX_W-1:0]   out_base;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign in_tri = s_axis_tdata[215:0];
  assign m_axis_tdata = {out_base, out_tri};

  stsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_levels (s_axis_tdata[218:216]),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  stsd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tri      (in_tri),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_tri     (out_tri),
    .out_base    (out_base),
    .out_last    (m_axis_tlast)
  );

endmodule
`default_nettype wire
